FILE: src/dlr_pkg.sv
// shared types, widths and codes of the depth line rasteriser
// no dependencies
`default_nettype none

package dlr_pkg;

  localparam int COORD_W      = 12;
  localparam int DEPTH_W      = 32;
  localparam int COLOR_W      = 24;
  localparam int PIX_W        = 6;
  localparam int SIDE_W       = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int DEF_MAX_SIDE = 64;

  localparam int EXT_W   = COORD_W;
  localparam int MINOR_W = COORD_W + 2;
  localparam int NUM_W   = DEPTH_W + 1;
  localparam int SLOPE_W = DEPTH_W + 2;
  localparam int Z_W     = 48;
  localparam int ITER_W  = $clog2(NUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV_Z,
    F_DIV_K,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_RUN,
    W_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic                        x_major;
    logic                        up;
    logic [PIX_W-1:0]            major;
    logic signed [MINOR_W-1:0]   minor;
    logic [SIDE_W-1:0]           nlim;
    logic [EXT_W-1:0]            step_a;
    logic [EXT_W-1:0]            dvs;
    logic [EXT_W-1:0]            rem;
    logic signed [SLOPE_W-1:0]   slope;
    logic signed [Z_W-1:0]       depth;
    logic [PIX_W-1:0]            count;
    logic [COLOR_W-1:0]          color;
  } walk_cmd_t;

endpackage

`default_nettype wire

FILE: src/dlr_fifo.sv
// two-entry queue between line setup and pixel walk
// no package dependencies
`default_nettype none

module dlr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push && !full) wptr_r <= ~wptr_r;
      if (pop && !empty) rptr_r <= ~rptr_r;
      if ((push && !full) && !(pop && !empty)) cnt_r <= cnt_r + 2'd1;
      else if (!(push && !full) && (pop && !empty)) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: src/dlr_front.sv
// line setup: endpoint ordering, clipping limits, slope and start offset division
// depends on dlr_pkg
`default_nettype none

module dlr_front #(
  parameter int MAX_SIDE = dlr_pkg::DEF_MAX_SIDE
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dlr_pkg::COORD_W-1:0]    in_start_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]    in_start_y,
  input  logic signed [dlr_pkg::DEPTH_W-1:0]    in_start_depth,
  input  logic signed [dlr_pkg::COORD_W-1:0]    in_end_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]    in_end_y,
  input  logic signed [dlr_pkg::DEPTH_W-1:0]    in_end_depth,
  input  logic [dlr_pkg::COLOR_W-1:0]           in_line_color,
  input  logic [dlr_pkg::SIDE_W-1:0]            canvas_width,
  input  logic [dlr_pkg::SIDE_W-1:0]            canvas_height,
  output logic                                  push,
  output dlr_pkg::walk_cmd_t                    push_cmd,
  input  logic                                  full
);

  import dlr_pkg::*;

  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

  front_state_t state_r, state_nxt;

  logic signed [COORD_W:0]    dx, dy;
  logic [EXT_W-1:0]           adx, ady, mlen, alen;
  logic                       x_major, swp, zero_len, up, accept, empty_line;
  logic signed [COORD_W-1:0]  ms, ns, ne;
  logic signed [DEPTH_W-1:0]  zs, ze;
  logic signed [NUM_W-1:0]    diff;
  logic [SIDE_W-1:0]          w_eff, h_eff, mlim, nlim;
  logic [EXT_W-1:0]           k0;
  logic signed [MINOR_W-1:0]  k1a, k1, k0s;

  walk_cmd_t                  cmd_r;
  logic signed [NUM_W-1:0]    diff_r;
  logic [EXT_W-1:0]           k0_r;
  logic signed [DEPTH_W-1:0]  zs_r;
  logic signed [COORD_W-1:0]  ns_r;
  logic [EXT_W-1:0]           off_r;

  logic [NUM_W-1:0]           num_r, num_nxt;
  logic [EXT_W-1:0]           drem_r, drem_nxt;
  logic [ITER_W-1:0]          iter_r;
  logic [EXT_W:0]             trial;
  logic                       ge, div_last;
  logic [SLOPE_W-1:0]         q_ext;

  assign dx = $signed({in_end_x[COORD_W-1], in_end_x}) -
              $signed({in_start_x[COORD_W-1], in_start_x});
  assign dy = $signed({in_end_y[COORD_W-1], in_end_y}) -
              $signed({in_start_y[COORD_W-1], in_start_y});
  assign adx = dx[COORD_W] ? EXT_W'(-dx) : EXT_W'(dx);
  assign ady = dy[COORD_W] ? EXT_W'(-dy) : EXT_W'(dy);
  assign zero_len = (dx == '0) && (dy == '0);
  assign x_major  = !(ady > adx);
  assign swp  = x_major ? (in_start_x > in_end_x) : (in_start_y > in_end_y);
  assign ms   = x_major ? (swp ? in_end_x : in_start_x) : (swp ? in_end_y : in_start_y);
  assign ns   = x_major ? (swp ? in_end_y : in_start_y) : (swp ? in_end_x : in_start_x);
  assign ne   = x_major ? (swp ? in_start_y : in_end_y) : (swp ? in_start_x : in_end_x);
  assign zs   = (zero_len || swp) ? in_end_depth : in_start_depth;
  assign ze   = swp ? in_start_depth : in_end_depth;
  assign up   = ne > ns;
  assign mlen = x_major ? adx : ady;
  assign alen = x_major ? ady : adx;
  assign diff = zero_len ? '0 :
                $signed({ze[DEPTH_W-1], ze}) - $signed({zs[DEPTH_W-1], zs});

  assign w_eff = (canvas_width  > SIDE_MAX) ? SIDE_MAX : canvas_width;
  assign h_eff = (canvas_height > SIDE_MAX) ? SIDE_MAX : canvas_height;
  assign mlim  = x_major ? w_eff : h_eff;
  assign nlim  = x_major ? h_eff : w_eff;

  assign k0  = ms[COORD_W-1] ? EXT_W'(-$signed({ms[COORD_W-1], ms})) : '0;
  assign k0s = $signed({2'b00, k0});
  assign k1a = $signed({{(MINOR_W-SIDE_W){1'b0}}, mlim}) - MINOR_W'(1) -
               $signed({{2{ms[COORD_W-1]}}, ms});
  assign k1  = ($signed({2'b00, mlen}) < k1a) ? $signed({2'b00, mlen}) : k1a;
  assign empty_line = k1 < k0s;

  assign accept = in_valid && in_ready;

  // restoring division step, one quotient bit a cycle
  assign trial    = {drem_r, num_r[NUM_W-1]};
  assign ge       = trial >= {1'b0, cmd_r.dvs};
  assign drem_nxt = ge ? EXT_W'(trial - {1'b0, cmd_r.dvs}) : trial[EXT_W-1:0];
  assign num_nxt  = {num_r[NUM_W-2:0], ge};
  assign div_last = iter_r == ITER_W'(NUM_W - 1);
  assign q_ext    = {1'b0, num_nxt};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept && !empty_line) state_nxt = F_DIV_Z;
      F_DIV_Z: if (div_last) state_nxt = F_DIV_K;
      F_DIV_K: if (div_last) state_nxt = F_MUL;
      F_MUL:   state_nxt = F_PUSH;
      F_PUSH:  if (!full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state_r)
      F_IDLE:  in_ready = 1'b1;
      F_PUSH:  push = !full;
      default: begin
        in_ready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  assign push_cmd = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          cmd_r.x_major <= x_major;
          cmd_r.up      <= up;
          cmd_r.major   <= PIX_W'($signed({{2{ms[COORD_W-1]}}, ms}) + k0s);
          cmd_r.nlim    <= nlim;
          cmd_r.step_a  <= alen;
          cmd_r.dvs     <= zero_len ? EXT_W'(1) : mlen;
          cmd_r.count   <= PIX_W'(k1 - k0s);
          cmd_r.color   <= in_line_color;
          diff_r        <= diff;
          k0_r          <= k0;
          zs_r          <= zs;
          ns_r          <= ns;
          num_r         <= diff[NUM_W-1] ? NUM_W'(-diff) : NUM_W'(diff);
          drem_r        <= '0;
          iter_r        <= '0;
        end
      end
      F_DIV_Z: begin
        if (div_last) begin
          cmd_r.slope <= diff_r[NUM_W-1] ? $signed(-q_ext) : $signed(q_ext);
          num_r       <= NUM_W'({{EXT_W{1'b0}}, k0_r} * {{EXT_W{1'b0}}, cmd_r.step_a});
          drem_r      <= '0;
          iter_r      <= '0;
        end else begin
          iter_r <= iter_r + ITER_W'(1);
          drem_r <= drem_nxt;
          num_r  <= num_nxt;
        end
      end
      F_DIV_K: begin
        iter_r <= iter_r + ITER_W'(1);
        drem_r <= drem_nxt;
        num_r  <= num_nxt;
        if (div_last) begin
          off_r     <= num_nxt[EXT_W-1:0];
          cmd_r.rem <= drem_nxt;
        end
      end
      F_MUL: begin
        cmd_r.depth <= Z_W'($signed({{(Z_W-DEPTH_W){zs_r[DEPTH_W-1]}}, zs_r}) +
                        Z_W'($signed({1'b0, k0_r}) * cmd_r.slope));
        cmd_r.minor <= cmd_r.up ?
                       $signed({{2{ns_r[COORD_W-1]}}, ns_r}) + $signed({2'b00, off_r}) :
                       $signed({{2{ns_r[COORD_W-1]}}, ns_r}) - $signed({2'b00, off_r});
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/dlr_walk.sv
// pixel walk: steps the major axis, tracks minor error and depth, emits pixels
// depends on dlr_pkg
`default_nettype none

module dlr_walk (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cmd_empty,
  input  dlr_pkg::walk_cmd_t                   cmd,
  output logic                                 cmd_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dlr_pkg::PIX_W-1:0]            out_pixel_x,
  output logic [dlr_pkg::PIX_W-1:0]            out_pixel_y,
  output logic signed [dlr_pkg::DEPTH_W-1:0]   out_pixel_depth,
  output logic [dlr_pkg::COLOR_W-1:0]          out_pixel_color,
  output logic                                 out_last_pixel
);

  import dlr_pkg::*;

  localparam logic signed [Z_W-1:0] Z_MAX = Z_W'({1'b0, {(DEPTH_W-1){1'b1}}});
  localparam logic signed [Z_W-1:0] Z_MIN = -Z_MAX - Z_W'(1);

  walk_state_t state_r, state_nxt;
  walk_cmd_t   w_r;

  logic                         pend_valid_r;
  logic [PIX_W-1:0]             pend_x_r, pend_y_r;
  logic signed [DEPTH_W-1:0]    pend_z_r;

  logic                         out_valid_r, out_last_r;
  logic [PIX_W-1:0]             out_x_r, out_y_r;
  logic signed [DEPTH_W-1:0]    out_z_r;
  logic [COLOR_W-1:0]           out_color_r;

  logic                         in_canvas, out_free, adv, out_load, flush_load, step_carry;
  logic [EXT_W:0]               rem_sum;
  logic signed [DEPTH_W-1:0]    z_sat;
  logic [PIX_W-1:0]             minor_pix;

  assign in_canvas = !w_r.minor[MINOR_W-1] &&
                     (w_r.minor < $signed({{(MINOR_W-SIDE_W){1'b0}}, w_r.nlim}));
  assign out_free = !out_valid_r || out_ready;
  assign adv      = (state_r == W_RUN) && (!in_canvas || !pend_valid_r || out_free);
  assign flush_load = (state_r == W_FLUSH) && pend_valid_r && out_free;
  assign out_load = (adv && in_canvas && pend_valid_r) || flush_load;

  assign rem_sum    = {1'b0, w_r.rem} + {1'b0, w_r.step_a};
  assign step_carry = rem_sum >= {1'b0, w_r.dvs};
  assign minor_pix  = w_r.minor[PIX_W-1:0];
  assign z_sat = (w_r.depth > Z_MAX) ? DEPTH_W'(Z_MAX) :
                 (w_r.depth < Z_MIN) ? DEPTH_W'(Z_MIN) : DEPTH_W'(w_r.depth);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      W_IDLE:  if (!cmd_empty) state_nxt = W_RUN;
      W_RUN:   if (adv && (w_r.count == '0)) state_nxt = W_FLUSH;
      W_FLUSH: if (!pend_valid_r || out_free) state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    unique case (state_r)
      W_IDLE:  cmd_pop = !cmd_empty;
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= W_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      w_r <= cmd;
    end else if (adv) begin
      w_r.major <= w_r.major + PIX_W'(1);
      w_r.count <= w_r.count - PIX_W'(1);
      w_r.depth <= w_r.depth + Z_W'(w_r.slope);
      if (step_carry) begin
        w_r.rem   <= EXT_W'(rem_sum - {1'b0, w_r.dvs});
        w_r.minor <= w_r.up ? w_r.minor + MINOR_W'(1) : w_r.minor - MINOR_W'(1);
      end else begin
        w_r.rem <= rem_sum[EXT_W-1:0];
      end
    end
  end

  // one pixel held back so the final one can be flagged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (adv && in_canvas) begin
      pend_valid_r <= 1'b1;
    end else if (flush_load) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_canvas) begin
      pend_x_r <= w_r.x_major ? w_r.major : minor_pix;
      pend_y_r <= w_r.x_major ? minor_pix : w_r.major;
      pend_z_r <= z_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r     <= pend_x_r;
      out_y_r     <= pend_y_r;
      out_z_r     <= pend_z_r;
      out_color_r <= w_r.color;
      out_last_r  <= flush_load;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_depth = out_z_r;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == W_IDLE) |-> !pend_valid_r)
    else $error("pending pixel left over while walk idle");

  a_flush_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    flush_load |=> (out_valid_r && out_last_r))
    else $error("flushed pixel not marked last");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (state_r == W_RUN))
    else $error("walk did not start after taking a line");

endmodule

`default_nettype wire

FILE: src/depth_line_rasterizer_top.sv
// Line rasteriser with depth interpolation. One line transaction is set up by the front
// (ordering, clip limits, a restoring division for the depth slope and another for the
// start offset of the minor axis, then a multiply) and queued; the walk then steps the
// clipped major span (at most 64 steps) one position per cycle while the output is not
// stalled, emitting the pixels that fall on the canvas, and it overlaps with the front.
// Lines whose major span misses the canvas are dropped by the front and produce no pixels.
`default_nettype none

module depth_line_rasterizer_top #(
  parameter int MAX_SIDE = dlr_pkg::DEF_MAX_SIDE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlr_pkg::SIDE_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [dlr_pkg::DEPTH_W-1:0]   in_start_depth,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_end_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_end_y,
  input  logic signed [dlr_pkg::DEPTH_W-1:0]   in_end_depth,
  input  logic [dlr_pkg::COLOR_W-1:0]          in_line_color,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dlr_pkg::PIX_W-1:0]            out_pixel_x,
  output logic [dlr_pkg::PIX_W-1:0]            out_pixel_y,
  output logic signed [dlr_pkg::DEPTH_W-1:0]   out_pixel_depth,
  output logic [dlr_pkg::COLOR_W-1:0]          out_pixel_color,
  output logic                                 out_last_pixel
);

  import dlr_pkg::*;

  localparam int CMD_W = $bits(walk_cmd_t);

  logic [SIDE_W-1:0] canvas_width_r, canvas_height_r;
  logic              push, full, pop, empty;
  walk_cmd_t         push_cmd, pop_cmd;
  logic [CMD_W-1:0]  pop_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= SIDE_W'(64);
      canvas_height_r <= SIDE_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dlr_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_start_x, .in_start_y, .in_start_depth,
    .in_end_x, .in_end_y, .in_end_depth, .in_line_color,
    .canvas_width (canvas_width_r),
    .canvas_height(canvas_height_r),
    .push, .push_cmd, .full
  );

  dlr_fifo #(.WIDTH(CMD_W)) u_fifo (
    .clk, .rst_n,
    .push, .push_data(push_cmd), .full,
    .pop, .pop_data(pop_bits), .empty
  );

  assign pop_cmd = walk_cmd_t'(pop_bits);

  dlr_walk u_walk (
    .clk, .rst_n,
    .cmd_empty(empty), .cmd(pop_cmd), .cmd_pop(pop),
    .out_valid, .out_ready,
    .out_pixel_x, .out_pixel_y, .out_pixel_depth, .out_pixel_color, .out_last_pixel
  );

endmodule

`default_nettype wire
